[hw/rtl/tblr_pkg.sv]
// Package for the tile background line renderer: types, constants and register codes.
`default_nettype none

package tblr_pkg;

  // Line geometry
  localparam int unsigned SCREEN_WIDTH = 160;
  localparam int unsigned GROUPS       = SCREEN_WIDTH / 8;
  localparam int unsigned GROUP_W      = 5;
  localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(GROUPS - 1);

  // Video memory
  localparam int unsigned VRAM_BYTES = 8192;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);

  // Tile maps live at 0x9800/0x9C00, i.e. offsets 0x1800/0x1C00: top two offset bits set
  localparam logic [1:0] MAP_REGION = 2'b11;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_ENABLE     = 3'd0,
    CFG_MAP_HIGH      = 3'd1,
    CFG_TILE_UNSIGNED = 3'd2,
    CFG_SCROLL_Y      = 3'd3,
    CFG_SHADE_MAP     = 3'd4
  } tblr_cfg_idx_e;

  // Reset values of the registers
  localparam logic       RST_BG_ENABLE     = 1'b1;
  localparam logic       RST_MAP_HIGH      = 1'b0;
  localparam logic       RST_TILE_UNSIGNED = 1'b1;
  localparam logic [7:0] RST_SCROLL_Y      = 8'd0;
  localparam logic [7:0] RST_SHADE_MAP     = 8'd252;

  // Input item operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } tblr_op_e;

  // Command kinds after classification
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_BLANK  = 2'd2
  } tblr_cmd_kind_e;

  typedef struct packed {
    logic        op;
    logic [12:0] vram_offset;
    logic [7:0]  vram_byte;
    logic [7:0]  screen_line;
  } tblr_in_t;

  typedef struct packed {
    logic [15:0]        pixel_group;
    logic [GROUP_W-1:0] group_index;
    logic [7:0]         line_number;
    logic               last;
  } tblr_out_t;

  typedef struct packed {
    logic       bg_enable;
    logic       map_select_high;
    logic       tile_data_unsigned;
    logic [7:0] scroll_y;
    logic [7:0] shade_map;
  } tblr_cfg_t;

  // Decoded command handed from front to back
  typedef struct packed {
    tblr_cmd_kind_e     kind;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
    logic [7:0]         line;
    logic               map_high;
    logic [4:0]         map_row;
    logic [2:0]         tile_row;
    logic               tile_unsigned;
  } tblr_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/tblr_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module tblr_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/tblr_front.sv]
// Front end: takes input items, decodes them into commands for the back end.
`default_nettype none

module tblr_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tblr_pkg::tblr_in_t  in_data_i,
  input  wire tblr_pkg::tblr_cfg_t cfg_i,
  output logic                     push_o,
  output tblr_pkg::tblr_cmd_t      cmd_o,
  input  wire logic                q_full_i
);

  import tblr_pkg::*;

  tblr_cmd_t  cmd_d, cmd_q;
  logic       cmd_valid_q;
  logic       accept;
  logic [7:0] y_sum;

  // Scrolled line, wraps at 256
  assign y_sum = in_data_i.screen_line + cfg_i.scroll_y;

  // Classify the item
  always_comb begin
    cmd_d               = '0;
    cmd_d.addr          = in_data_i.vram_offset;
    cmd_d.data          = in_data_i.vram_byte;
    cmd_d.line          = in_data_i.screen_line;
    cmd_d.map_high      = cfg_i.map_select_high;
    cmd_d.map_row       = y_sum[7:3];
    cmd_d.tile_row      = y_sum[2:0];
    cmd_d.tile_unsigned = cfg_i.tile_data_unsigned;
    if (in_data_i.op == OP_WRITE) begin
      cmd_d.kind = CMD_WRITE;
    end else if (cfg_i.bg_enable) begin
      cmd_d.kind = CMD_RENDER;
    end else begin
      cmd_d.kind = CMD_BLANK;
    end
  end

  // One command register; held while the queue is full
  assign push_o     = cmd_valid_q && !q_full_i;
  assign in_stall_o = cmd_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
    end else if (push_o) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tblr_queue.sv]
// Short command queue between the front and back ends.
`default_nettype none

module tblr_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tblr_pkg::tblr_cmd_t  cmd_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output tblr_pkg::tblr_cmd_t       cmd_o,
  output logic                      valid_o
);

  import tblr_pkg::*;

  tblr_cmd_t           entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tblr_back.sv]
// Back end: video memory, tile fetch sequencer and output register.
`default_nettype none

module tblr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire tblr_pkg::tblr_cmd_t cmd_i,
  output logic                     pop_o,
  input  wire logic [7:0]          palette_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tblr_pkg::tblr_out_t      out_data_o
);

  import tblr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_PIX,
    S_BLANK
  } state_e;

  state_e              state_q, state_d;
  logic [GROUP_W-1:0]  k_q, k_d;
  tblr_cmd_t           job_q, job_d;
  logic [VRAM_AW-1:0]  addr_q, addr_d;
  logic [7:0]          lo_q, lo_d;
  tblr_out_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                ram_we, ram_re;
  logic [VRAM_AW-1:0]  ram_addr;
  logic [7:0]          ram_rdata;
  logic [VRAM_AW-1:0]  tile_addr;
  logic                slot_free;
  logic                out_load;
  logic [GROUP_W-1:0]  k_next;

  // Palette-map two bit planes into eight 2-bit shades, leftmost first
  function automatic logic [15:0] make_group(input logic [7:0] d0, input logic [7:0] d1,
                                             input logic [7:0] pal);
    logic [15:0] g;
    logic [1:0]  color;
    g = '0;
    for (int i = 0; i < 8; i++) begin
      color         = {d1[7-i], d0[7-i]};
      g[15-2*i -: 2] = pal[2*color +: 2];
    end
    return g;
  endfunction

  tblr_ram #(
    .DATA_W (8),
    .DEPTH  (VRAM_BYTES)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (job_d.data),
    .rdata_o (ram_rdata)
  );

  // Tile row address; signed mode lands around 0x9000 and wraps in the memory
  assign tile_addr = {~job_q.tile_unsigned & ~ram_rdata[7], ram_rdata, job_q.tile_row, 1'b0};

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign k_next      = k_q + 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: map read, low plane, high plane, emit (overlapped with next map read)
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    job_d    = job_q;
    addr_d   = addr_q;
    lo_d     = lo_q;
    out_d    = out_q;
    out_load = 1'b0;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = {MAP_REGION, job_q.map_high, job_q.map_row, k_q};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          job_d = cmd_i;
          k_d   = '0;
          unique case (cmd_i.kind)
            CMD_WRITE: begin
              ram_we   = 1'b1;
              ram_addr = cmd_i.addr;
            end
            CMD_RENDER: begin
              ram_re   = 1'b1;
              ram_addr = {MAP_REGION, cmd_i.map_high, cmd_i.map_row, {GROUP_W{1'b0}}};
              state_d  = S_LO;
            end
            default: begin
              state_d = S_BLANK;
            end
          endcase
        end
      end
      S_LO: begin
        ram_re   = 1'b1;
        ram_addr = tile_addr;
        addr_d   = tile_addr;
        state_d  = S_HI;
      end
      S_HI: begin
        ram_re   = 1'b1;
        ram_addr = {addr_q[VRAM_AW-1:1], 1'b1};
        lo_d     = ram_rdata;
        state_d  = S_PIX;
      end
      S_PIX: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_d.pixel_group = make_group(lo_q, ram_rdata, palette_i);
          out_d.group_index = k_q;
          out_d.line_number = job_q.line;
          out_d.last        = (k_q == LAST_GROUP);
          if (k_q == LAST_GROUP) begin
            state_d = S_IDLE;
          end else begin
            k_d      = k_next;
            ram_re   = 1'b1;
            ram_addr = {MAP_REGION, job_q.map_high, job_q.map_row, k_next};
            state_d  = S_LO;
          end
        end
      end
      S_BLANK: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_d.pixel_group = '0;
          out_d.group_index = k_q;
          out_d.line_number = job_q.line;
          out_d.last        = (k_q == LAST_GROUP);
          if (k_q == LAST_GROUP) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_next;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    addr_q <= addr_d;
    lo_q   <= lo_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

[hw/rtl/tile_background_line_render.sv]
// Top level of the tile background line renderer: config registers and block wiring.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  in_data_i   (tblr_in_t)
//   out      output     out_valid_o/out_stall_i out_data_o (tblr_out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A memory write is done as the back end takes the item. A render item does a map
// read, a low plane read and a high plane read for each 8-pixel group on the one
// video memory port, and an emit step for each group; a disabled background
// emits one group per cycle while the output is not stalled. The front register
// and a 2-entry queue take new items while the back end works. Reset is
// asynchronous, active low; the video memory is not cleared. Output stalls hold
// the back end at its emit step.
`default_nettype none

module tile_background_line_render (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire tblr_pkg::tblr_in_t                    in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output tblr_pkg::tblr_out_t                        out_data_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [tblr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [tblr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  import tblr_pkg::*;

  tblr_cfg_t cfg_q;
  tblr_cmd_t front_cmd, queue_cmd;
  logic      push, pop, q_full, q_valid;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bg_enable          <= RST_BG_ENABLE;
      cfg_q.map_select_high    <= RST_MAP_HIGH;
      cfg_q.tile_data_unsigned <= RST_TILE_UNSIGNED;
      cfg_q.scroll_y           <= RST_SCROLL_Y;
      cfg_q.shade_map          <= RST_SHADE_MAP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BG_ENABLE:     cfg_q.bg_enable          <= cfg_data_i[0];
        CFG_MAP_HIGH:      cfg_q.map_select_high    <= cfg_data_i[0];
        CFG_TILE_UNSIGNED: cfg_q.tile_data_unsigned <= cfg_data_i[0];
        CFG_SCROLL_Y:      cfg_q.scroll_y           <= cfg_data_i;
        CFG_SHADE_MAP:     cfg_q.shade_map          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tblr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .q_full_i   (q_full)
  );

  tblr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .valid_o (q_valid)
  );

  tblr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .palette_i   (cfg_q.shade_map),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
